/* src/thls_pkg.sv */
// Shared types and constants for the two-limit homing sequencer.
package thls_pkg;

   localparam int PosWidth = 32;
   localparam int DistWidth = 31;
   localparam int CsrIndexWidth = 1;
   localparam logic [DistWidth-1:0] DistanceReset = DistWidth'(100000);

   typedef enum logic [2:0] {
      PH_START    = 3'd0,
      PH_TRAVEL1  = 3'd1,
      PH_STOP1    = 3'd2,
      PH_TRAVEL2  = 3'd3,
      PH_STOP2    = 3'd4,
      PH_COMPLETE = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_REL   = 3'd1,
      CMD_ESTOP = 3'd2,
      CMD_ABS   = 3'd3,
      CMD_REDEF = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      EXIT_NONE  = 3'd0,
      EXIT_ERROR = 3'd1,
      EXIT_OPEN  = 3'd2,
      EXIT_CLOSE = 3'd3,
      EXIT_AUTO  = 3'd4
   } exit_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_HOMING_DISTANCE = 1'b0,
      CSR_FIRST_DIRECTION = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [DistWidth-1:0] homing_distance;
      logic                 first_direction_negative;
   } cfg_type;

   typedef struct packed {
      phase_type            phase;
      logic [PosWidth-1:0]  on_pos;
      logic [PosWidth-1:0]  off_pos;
      logic [PosWidth-1:0]  close_pos;
      logic                 driver_on;
      exit_type             exit_code;
   } state_type;

   typedef struct packed {
      logic on_sw;
      logic off_sw;
      logic [PosWidth-1:0] pos;
      logic done;
      logic vzero;
      logic r_open;
      logic r_close;
      logic r_auto;
   } tick_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [PosWidth-1:0] target;
      state_type           next;
   } step_type;

endpackage

/* src/thls_if.sv */
// Channel interfaces for tick input, result output and register writes.
interface thls_req_if;
   logic               valid;
   logic               ready;
   logic               on_box_switch;
   logic               off_box_switch;
   logic signed [31:0] motor_position;
   logic               motion_done;
   logic               velocity_zero;
   logic               request_open;
   logic               request_close;
   logic               request_auto;

   modport source (output valid, on_box_switch, off_box_switch, motor_position,
                   motion_done, velocity_zero, request_open, request_close,
                   request_auto, input ready);
   modport sink (input valid, on_box_switch, off_box_switch, motor_position,
                 motion_done, velocity_zero, request_open, request_close,
                 request_auto, output ready);
endinterface

interface thls_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         motor_command;
   logic signed [31:0] motor_target;
   logic               driver_enable;
   logic [2:0]         phase;
   logic signed [31:0] close_position;
   logic [2:0]         exit_to;
   logic               indicator_on;

   modport source (output valid, motor_command, motor_target, driver_enable, phase,
                   close_position, exit_to, indicator_on, input ready);
   modport sink (input valid, motor_command, motor_target, driver_enable, phase,
                 close_position, exit_to, indicator_on, output ready);
endinterface

interface thls_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [30:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* src/two_limit_homing_sequencer_top.sv */
// Top level of the two-limit homing sequencer.
//
// The req_ch channel carries one control tick per transfer: both limit
// switches, the motor position, the motion flags and the mode requests.
// Every accepted tick gives exactly one transfer on rsp_ch with the motor
// command, its target, the driver enable, the homing phase, the close
// position, the exit code and the indicator.
// The result appears in the cycle after the tick is accepted. A new tick can
// be accepted in every cycle while results are taken; the single result
// register sets that figure. When the receiver stalls, the result holds and
// req_ch.ready stays low until the waiting result is taken, or goes high in
// the same cycle it is. Registers are written through csr_ch, which is
// always ready; index 0 is the homing distance and index 1 the first
// direction. Write them only while no tick is in flight.
// Synchronous reset returns the sequence to the start phase with the
// driver enabled, clears positions and exit code, and restores the
// register defaults. Once an exit is reported the block holds until reset.
module two_limit_homing_sequencer_top (
   input logic          clock,
   input logic          reset,
   thls_req_if.sink     req_ch,
   thls_rsp_if.source   rsp_ch,
   thls_csr_if.sink     csr_ch
);
   import thls_pkg::*;

   cfg_type   cfg_ff;
   state_type st_ff;
   tick_type  tick;
   step_type  step;
   logic      rsp_valid_ff;
   logic      accept;

   cmd_type             cmd_ff;
   logic [PosWidth-1:0] target_ff;

   assign tick.on_sw   = req_ch.on_box_switch;
   assign tick.off_sw  = req_ch.off_box_switch;
   assign tick.pos     = PosWidth'(req_ch.motor_position);
   assign tick.done    = req_ch.motion_done;
   assign tick.vzero   = req_ch.velocity_zero;
   assign tick.r_open  = req_ch.request_open;
   assign tick.r_close = req_ch.request_close;
   assign tick.r_auto  = req_ch.request_auto;

   thls_step u_step (
      .st   (st_ff),
      .tick (tick),
      .cfg  (cfg_ff),
      .res  (step)
   );

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.homing_distance <= DistanceReset;
         cfg_ff.first_direction_negative <= 1'b0;
      end else if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_HOMING_DISTANCE: cfg_ff.homing_distance <= csr_ch.data;
            CSR_FIRST_DIRECTION: cfg_ff.first_direction_negative <= csr_ch.data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.phase <= PH_START;
         st_ff.on_pos <= '0;
         st_ff.off_pos <= '0;
         st_ff.close_pos <= '0;
         st_ff.driver_on <= 1'b1;
         st_ff.exit_code <= EXIT_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            st_ff <= step.next;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= step.cmd;
         target_ff <= step.target;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.motor_command  = 3'(cmd_ff);
   assign rsp_ch.motor_target   = 32'(target_ff);
   assign rsp_ch.driver_enable  = st_ff.driver_on;
   assign rsp_ch.phase          = 3'(st_ff.phase);
   assign rsp_ch.close_position = 32'(st_ff.close_pos);
   assign rsp_ch.exit_to        = 3'(st_ff.exit_code);
   assign rsp_ch.indicator_on   = (st_ff.exit_code == EXIT_NONE);

`ifndef SYNTH
   // Once an exit is reported, the sequence state no longer moves.
   assert property (@(posedge clock) disable iff (reset)
      (st_ff.exit_code != EXIT_NONE) |=> (st_ff == $past(st_ff)))
      else $error("state changed after exit");

   // The driver is only disabled by reaching the complete phase.
   assert property (@(posedge clock) disable iff (reset)
      !st_ff.driver_on |-> (st_ff.phase == PH_COMPLETE))
      else $error("driver disabled outside complete phase");

   // Every accepted tick leaves a result waiting in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted tick produced no result");
`endif

endmodule

/* src/thls_step.sv */
// Next-state and motor command logic for one homing tick.
module thls_step (
   input  thls_pkg::state_type st,
   input  thls_pkg::tick_type  tick,
   input  thls_pkg::cfg_type   cfg,
   output thls_pkg::step_type  res
);
   import thls_pkg::*;

   logic [PosWidth-1:0] first_amount;
   logic                any_request;
   exit_type            ex;
   state_type           ns;

   always_comb begin
      first_amount = cfg.first_direction_negative ?
                     (PosWidth'(0) - PosWidth'(cfg.homing_distance)) :
                     PosWidth'(cfg.homing_distance);
      any_request = tick.r_open | tick.r_close | tick.r_auto;
      ns = st;
      res.cmd = CMD_NONE;
      res.target = '0;
      ex = EXIT_NONE;
      if (st.exit_code == EXIT_NONE) begin
         case (st.phase)
            PH_START: begin
               res.cmd = CMD_REL;
               res.target = first_amount;
               ns.phase = PH_TRAVEL1;
            end
            PH_TRAVEL1: begin
               if (tick.on_sw) begin
                  ns.on_pos = tick.pos;
                  res.cmd = CMD_ESTOP;
                  ns.phase = PH_STOP1;
               end
            end
            PH_STOP1: begin
               if (tick.done || tick.vzero) begin
                  res.cmd = CMD_ABS;
                  res.target = PosWidth'(0) - first_amount;
                  ns.phase = PH_TRAVEL2;
               end
            end
            PH_TRAVEL2: begin
               if (tick.off_sw) begin
                  ns.off_pos = tick.pos;
                  res.cmd = CMD_ESTOP;
                  ns.phase = PH_STOP2;
               end
            end
            PH_STOP2: begin
               if (tick.done) begin
                  ns.driver_on = 1'b0;
                  ns.on_pos = st.on_pos - st.off_pos;
                  ns.off_pos = '0;
                  ns.close_pos = st.off_pos - st.on_pos;
                  res.cmd = CMD_REDEF;
                  res.target = st.off_pos - st.on_pos;
                  ns.phase = PH_COMPLETE;
               end
            end
            default: begin
            end
         endcase

         if (tick.on_sw && tick.off_sw) begin
            ex = EXIT_ERROR;
         end
         if (ns.phase == PH_COMPLETE) begin
            if (tick.r_open) begin
               ex = EXIT_OPEN;
            end else if (tick.r_close) begin
               ex = EXIT_CLOSE;
            end else if (tick.r_auto) begin
               ex = EXIT_AUTO;
            end
         end else if (any_request) begin
            ex = EXIT_ERROR;
         end
         ns.exit_code = ex;
      end
      res.next = ns;
   end

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the two-limit homing sequencer top level.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import thls_pkg::*;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] target;
      logic        drive;
      phase_type   ph;
      logic [31:0] close;
      exit_type    ex;
      logic        lit;
   } report_type;

   typedef struct {
      bit          reconfig;
      logic [30:0] span;
      logic        neg;
      tick_type    tick;
      bit          check;
      report_type  want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;

   thls_req_if req_ch ();
   thls_rsp_if rsp_ch ();
   thls_csr_if csr_ch ();

   two_limit_homing_sequencer_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   logic [30:0] distance;
   logic        neg_first;
   phase_type   ph;
   logic [31:0] on_pos;
   logic [31:0] off_pos;
   logic [31:0] close_pos;
   logic        drv_on;
   exit_type    exit_cd;

   report_type due_reports[$];
   int      ticks_sent = 0;
   int      reports_seen = 0;
   int      csr_writes = 0;
   int      faults = 0;
   logic [5:0] phase_hits = '0;

   bit      calm = 1'b0;
   bit      choke = 1'b0;
   bit      random_started = 1'b0;
   bit      pin_on = 1'b0;
   report_type pin_want = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic report_type homing_tick(input tick_type t);
      report_type  r;
      logic [31:0] amount;
      exit_type    ex;
      r = '0;
      r.cmd = CMD_NONE;
      amount = neg_first ? -{1'b0, distance} : {1'b0, distance};
      if (exit_cd == EXIT_NONE) begin
         ex = EXIT_NONE;
         case (ph)
            PH_START: begin
               r.cmd = CMD_REL;
               r.target = amount;
               ph = PH_TRAVEL1;
            end
            PH_TRAVEL1: if (t.on_sw) begin
               on_pos = t.pos;
               r.cmd = CMD_ESTOP;
               ph = PH_STOP1;
            end
            PH_STOP1: if (t.done || t.vzero) begin
               r.cmd = CMD_ABS;
               r.target = -amount;
               ph = PH_TRAVEL2;
            end
            PH_TRAVEL2: if (t.off_sw) begin
               off_pos = t.pos;
               r.cmd = CMD_ESTOP;
               ph = PH_STOP2;
            end
            PH_STOP2: if (t.done) begin
               drv_on = 1'b0;
               on_pos = on_pos - off_pos;
               off_pos = '0;
               close_pos = -on_pos;
               r.cmd = CMD_REDEF;
               r.target = close_pos;
               ph = PH_COMPLETE;
            end
            default: ;
         endcase
         if (t.on_sw && t.off_sw) ex = EXIT_ERROR;
         if (ph == PH_COMPLETE) begin
            if (t.r_open) ex = EXIT_OPEN;
            else if (t.r_close) ex = EXIT_CLOSE;
            else if (t.r_auto) ex = EXIT_AUTO;
         end else if (t.r_open || t.r_close || t.r_auto) begin
            ex = EXIT_ERROR;
         end
         exit_cd = ex;
      end
      r.drive = drv_on;
      r.ph = ph;
      r.close = close_pos;
      r.ex = exit_cd;
      r.lit = (exit_cd == EXIT_NONE);
      return r;
   endfunction

   function automatic tick_type tk(input logic on_sw, off_sw, input logic [31:0] pos,
                                   input logic dn, vz);
      tick_type t;
      t = '0;
      t.on_sw = on_sw;
      t.off_sw = off_sw;
      t.pos = pos;
      t.done = dn;
      t.vzero = vz;
      return t;
   endfunction

   function automatic report_type rep(input cmd_type cmd, input logic [31:0] target,
                                      input phase_type p);
      report_type r;
      r = '0;
      r.cmd = cmd;
      r.target = target;
      r.drive = 1'b1;
      r.ph = p;
      r.ex = EXIT_NONE;
      r.lit = 1'b1;
      return r;
   endfunction

   function automatic tick_type homing_noise(input bit wild);
      tick_type    t;
      logic [63:0] bits;
      int          pick;
      bits = {$urandom, $urandom};
      t = bits[$bits(tick_type)-1:0];
      if (!wild) begin
         case ($urandom_range(3))
            0: t.pos = 32'h7FFF_FFFF;
            1: t.pos = 32'h8000_0000;
            default: t.pos = $urandom;
         endcase
         pick = $urandom_range(149);
         t.on_sw = (pick == 0);
         t.off_sw = (pick == 1);
         t.vzero = ($urandom_range(9) == 0);
         t.done = ($urandom_range(499) == 0);
         t.r_open = 1'b0;
         t.r_close = 1'b0;
         t.r_auto = 1'b0;
      end
      return t;
   endfunction

   function automatic void match(input string name, input logic [31:0] want, got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         faults++;
      end
   endfunction

   always @(posedge clock) begin : take_csr
      if (!reset && csr_ch.valid && csr_ch.ready) begin
         csr_writes++;
         case (csr_index_type'(csr_ch.index))
            CSR_HOMING_DISTANCE: distance = csr_ch.data;
            CSR_FIRST_DIRECTION: neg_first = csr_ch.data[0];
            default: ;
         endcase
      end
   end

   always @(posedge clock) begin : take_tick
      tick_type   t;
      report_type r;
      if (reset) begin
         distance = DistanceReset;
         neg_first = 1'b0;
         ph = PH_START;
         on_pos = '0;
         off_pos = '0;
         close_pos = '0;
         drv_on = 1'b1;
         exit_cd = EXIT_NONE;
      end else if (req_ch.valid && req_ch.ready) begin
         t = {req_ch.on_box_switch, req_ch.off_box_switch, req_ch.motor_position,
              req_ch.motion_done, req_ch.velocity_zero, req_ch.request_open,
              req_ch.request_close, req_ch.request_auto};
         r = homing_tick(t);
         phase_hits[r.ph] = 1'b1;
         if (pin_on) r = pin_want;
         due_reports.push_back(r);
      end
   end

   always @(posedge clock) begin : check_report
      report_type got;
      report_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.motor_command, rsp_ch.motor_target, rsp_ch.driver_enable,
                rsp_ch.phase, rsp_ch.close_position, rsp_ch.exit_to, rsp_ch.indicator_on};
         reports_seen++;
         if (due_reports.size() == 0) begin
            $error("Result transfer arrived with no tick waiting for it.");
            faults++;
         end else begin
            want = due_reports.pop_front();
            match("motor_command", want.cmd, got.cmd);
            match("motor_target", want.target, got.target);
            match("driver_enable", want.drive, got.drive);
            match("phase", want.ph, got.ph);
            match("close_position", want.close, got.close);
            match("exit_to", want.ex, got.ex);
            match("indicator_on", want.lit, got.lit);
         end
      end
   end

   initial begin : drain
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= !choke && (calm || $urandom_range(99) >= 11);
      end
   end

   initial begin : choke_rsp
      wait (random_started);
      @(posedge clock);
      choke <= 1'b1;
      repeat (80) @(posedge clock);
      choke <= 1'b0;
   end

   initial begin : watchdog
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   task automatic offer(input tick_type t, input bit check, input report_type want);
      while (!calm && $urandom_range(99) < 11) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.on_box_switch <= t.on_sw;
      req_ch.off_box_switch <= t.off_sw;
      req_ch.motor_position <= t.pos;
      req_ch.motion_done <= t.done;
      req_ch.velocity_zero <= t.vzero;
      req_ch.request_open <= t.r_open;
      req_ch.request_close <= t.r_close;
      req_ch.request_auto <= t.r_auto;
      pin_on <= check;
      pin_want <= want;
      do @(posedge clock); while (!req_ch.ready);
      ticks_sent++;
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (reports_seen != ticks_sent) @(posedge clock);
   endtask

   task automatic set_config(input logic [30:0] span, input logic neg);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= CSR_HOMING_DISTANCE;
      csr_ch.data <= span;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.index <= CSR_FIRST_DIRECTION;
      csr_ch.data <= {30'd0, neg};
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin : stimulus
      script_row_type script[$];
      tick_type    t;
      logic [30:0] span;
      logic        neg;
      req_ch.valid = 1'b0;
      req_ch.on_box_switch = 1'b0;
      req_ch.off_box_switch = 1'b0;
      req_ch.motor_position = '0;
      req_ch.motion_done = 1'b0;
      req_ch.velocity_zero = 1'b0;
      req_ch.request_open = 1'b0;
      req_ch.request_close = 1'b0;
      req_ch.request_auto = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      reset = 1'b1;

      script.push_back('{1'b1, 31'h7FFF_FFFF, 1'b1, tk(0, 0, 32'h0, 0, 0), 1'b1,
                         rep(CMD_REL, 32'h8000_0001, PH_TRAVEL1)});
      script.push_back('{1'b0, 31'h0, 1'b0, tk(0, 0, 32'h7FFF_FFFF, 1, 1), 1'b1,
                         rep(CMD_NONE, 32'h0, PH_TRAVEL1)});
      script.push_back('{1'b0, 31'h0, 1'b0, tk(0, 1, 32'h8000_0000, 0, 0), 1'b1,
                         rep(CMD_NONE, 32'h0, PH_TRAVEL1)});
      script.push_back('{1'b0, 31'h0, 1'b0, tk(1, 0, 32'h7FFF_FFFF, 0, 0), 1'b1,
                         rep(CMD_ESTOP, 32'h0, PH_STOP1)});
      script.push_back('{1'b0, 31'h0, 1'b0, tk(1, 0, 32'h0, 0, 0), 1'b1,
                         rep(CMD_NONE, 32'h0, PH_STOP1)});
      script.push_back('{1'b1, 31'h0, 1'b0, tk(0, 0, 32'hFFFF_FFFF, 0, 1), 1'b1,
                         rep(CMD_ABS, 32'h0, PH_TRAVEL2)});
      script.push_back('{1'b0, 31'h0, 1'b0, tk(1, 0, 32'hFFFF_FFFF, 0, 0), 1'b0,
                         report_type'('0)});
      script.push_back('{1'b0, 31'h0, 1'b0, tk(0, 0, 32'h8000_0000, 1, 1), 1'b0,
                         report_type'('0)});

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].reconfig) begin
            settle();
            set_config(script[i].span, script[i].neg);
         end
         offer(script[i].tick, script[i].check, script[i].want);
      end

      random_started <= 1'b1;
      for (int seg = 0; seg < 4; seg++) begin
         settle();
         case (seg)
            0: begin span = 31'h7FFF_FFFF; neg = 1'b0; end
            1: begin span = 31'h0; neg = 1'b1; end
            2: begin span = 31'($urandom); neg = $urandom_range(1); end
            default: begin span = 31'd1; neg = 1'b1; end
         endcase
         set_config(span, neg);
         calm <= (seg == 2);
         repeat (355) offer(homing_noise(1'b0), 1'b0, '0);
      end
      calm <= 1'b0;

      // Drive the sequence on to the second stop so that the exit tick also
      // carries the final redefine command when the random part fell short.
      settle();
      while (ph != PH_STOP2 && ph != PH_COMPLETE && exit_cd == EXIT_NONE) begin
         offer(tk(ph == PH_TRAVEL1, ph == PH_TRAVEL2, $urandom, 1'b0, 1'b1), 1'b0, '0);
         settle();
      end

      t = tk(1'b1, 1'b1, $urandom, 1'b1, 1'b0);
      t.r_open = $urandom_range(1);
      t.r_close = $urandom_range(1);
      t.r_auto = $urandom_range(1);
      offer(t, 1'b0, '0);
      repeat (20) offer(homing_noise(1'b1), 1'b0, '0);

      settle();
      repeat (5) @(posedge clock);
      if (due_reports.size() != 0) begin
         $error("%0d expected results never arrived.", due_reports.size());
         faults++;
      end
      $display("Sent %0d ticks across %0d register writes; phases reached %b, exit code %0d.",
               ticks_sent, csr_writes, phase_hits, exit_cd);
      if (faults == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

/* files.f */
src/thls_pkg.sv
src/thls_if.sv
src/thls_step.sv
src/two_limit_homing_sequencer_top.sv
dv/tb_top.sv
